// ===== rtl/scd_pkg.sv =====
// shared types and constants for the scan convergence detector
package scd_pkg;

  localparam int MAX_POINTS_DEFAULT = 1024;

  localparam int SAMPLE_W    = 24;
  localparam int TIME_W      = 22;
  localparam int TOL_W       = 40;
  localparam int INC_W       = 16;
  localparam int ACC_W       = 59;
  localparam int SQ_W        = 48;
  localparam int OUT_CNT_W   = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 40;

  localparam logic [TOL_W-1:0]  TOL_RESET      = TOL_W'(274878);
  localparam logic [INC_W-1:0]  TIME_INC_RESET = INC_W'(900);
  localparam logic [TIME_W-1:0] DEADLINE_MAX   = {TIME_W{1'b1}};
  localparam logic [ACC_W-1:0]  ACC_MAX        = {ACC_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE_SQUARED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_INCREMENT    = CFG_IDX_W'(1);

  // request codes
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // result status codes
  localparam logic [1:0] ST_SKIPPED      = 2'd0;
  localparam logic [1:0] ST_REF_STORED   = 2'd1;
  localparam logic [1:0] ST_NOT_CONVERGED = 2'd2;
  localparam logic [1:0] ST_CONVERGED    = 2'd3;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_REF,
    KIND_CMP
  } scd_kind_t;

  typedef struct packed {
    logic                       req_type;
    logic [TIME_W-1:0]          scan_time;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_point;
  } scd_point_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ACC_W-1:0]     sum_squares;
    logic [OUT_CNT_W-1:0] point_count;
  } scd_result_t;

  // per-point control carried from the front end into the accumulate pipeline
  typedef struct packed {
    logic                       emit;
    scd_kind_t                  kind;
    logic                       add;
    logic                       clr;
    logic                       resolve;
    logic [OUT_CNT_W-1:0]       count;
    logic signed [SAMPLE_W-1:0] sample;
  } scd_item_t;

  // end-of-scan decision sent back to the front end
  typedef struct packed {
    logic valid;
    logic flip;
  } scd_resolve_t;

endpackage

// ===== rtl/scan_convergence_detector.sv =====
// Scan convergence detector: takes one sample point per cycle from the point
// channel while point_stall is low, and gives one result at the last point of
// every scan. Points of a scan are compared against the reference scan held in
// a two-bank sample memory of 2 * 2^ceil(log2(MAX_POINTS)) words. A point goes
// through a three-stage pipeline (memory read, square, accumulate) into the
// result register. After the final point of a compared scan the point channel
// stalls until the convergence decision at the end of that pipeline, which a
// waiting result can delay, as the next scan's bank depends on it. The user is to
// write configuration through cfg_* while the block is idle; it is not enforced.

module scan_convergence_detector #(
  parameter int MAX_POINTS = scd_pkg::MAX_POINTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              point_valid,
  output logic                              point_stall,
  input  scd_pkg::scd_point_t               point,
  output logic                              result_valid,
  input  logic                              result_stall,
  output scd_pkg::scd_result_t              result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);

  logic [scd_pkg::TOL_W-1:0]           tolerance;
  logic [scd_pkg::INC_W-1:0]           time_increment;

  logic                                accept;
  logic                                take;
  logic                                pending;
  scd_pkg::scd_item_t                  item;
  scd_pkg::scd_resolve_t               resolve;
  logic                                mem_we;
  logic [AW:0]                         mem_waddr;
  logic signed [scd_pkg::SAMPLE_W-1:0] mem_wdata;
  logic                                mem_re;
  logic [AW:0]                         mem_raddr;
  logic signed [scd_pkg::SAMPLE_W-1:0] mem_rdata;
  logic [CW-1:0]                       ref_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= scd_pkg::TOL_RESET;
      time_increment <= scd_pkg::TIME_INC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scd_pkg::CFG_TOLERANCE_SQUARED: tolerance <= scd_pkg::TOL_W'(cfg_data);
        scd_pkg::CFG_TIME_INCREMENT:    time_increment <= scd_pkg::INC_W'(cfg_data);
        default: ;
      endcase
    end
  end

  scd_front #(
    .MAX_POINTS (MAX_POINTS),
    .CW         (CW),
    .AW         (AW)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .point_valid    (point_valid),
    .point          (point),
    .point_stall    (point_stall),
    .time_increment (time_increment),
    .take           (take),
    .resolve        (resolve),
    .accept         (accept),
    .item           (item),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .ref_count      (ref_count),
    .pending        (pending)
  );

  scd_bank_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  scd_accum #(
    .CW (CW)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .rdata        (mem_rdata),
    .tolerance    (tolerance),
    .ref_count    (ref_count),
    .take         (take),
    .resolve      (resolve),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTHESIS
  // the scan being written never shares an entry with the reference read
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("sample memory read and write hit the same entry");

  // a convergence decision only arrives while intake is held for it
  a_resolve_pending: assert property (@(posedge clk) disable iff (rst)
    resolve.valid |-> pending)
    else $error("convergence decision without a pending scan end");

  // the final point of a compared scan holds intake until it resolves
  a_hold_after_cmp: assert property (@(posedge clk) disable iff (rst)
    (accept && item.resolve) |=> (pending && point_stall))
    else $error("intake not held after final compared point");

  // a stored-reference result carries a nonzero count when its width fits the result
  a_ref_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == scd_pkg::ST_REF_STORED)) |-> (result.point_count != '0
      || CW > scd_pkg::OUT_CNT_W))
    else $error("reference stored with zero points");
`endif

endmodule

// ===== rtl/scd_bank_mem.sv =====
// two-bank sample store, one write port and one registered read port
module scd_bank_mem #(
  parameter int AW = 10
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [AW:0]                          waddr,
  input  logic signed [scd_pkg::SAMPLE_W-1:0]  wdata,
  input  logic                                 re,
  input  logic [AW:0]                          raddr,
  output logic signed [scd_pkg::SAMPLE_W-1:0]  rdata
);

  logic signed [scd_pkg::SAMPLE_W-1:0] mem [2**(AW+1)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/scd_front.sv =====
// point intake: deadline check, reference bookkeeping and bank addressing
module scd_front #(
  parameter int MAX_POINTS = scd_pkg::MAX_POINTS_DEFAULT,
  parameter int CW = $clog2(MAX_POINTS + 1),
  parameter int AW = $clog2(MAX_POINTS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                point_valid,
  input  scd_pkg::scd_point_t                 point,
  output logic                                point_stall,
  input  logic [scd_pkg::INC_W-1:0]           time_increment,
  input  logic                                take,
  input  scd_pkg::scd_resolve_t               resolve,
  output logic                                accept,
  output scd_pkg::scd_item_t                  item,
  output logic                                mem_we,
  output logic [AW:0]                         mem_waddr,
  output logic signed [scd_pkg::SAMPLE_W-1:0] mem_wdata,
  output logic                                mem_re,
  output logic [AW:0]                         mem_raddr,
  output logic [CW-1:0]                       ref_count,
  output logic                                pending
);

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

  logic                          have_ref;
  logic                          ref_bank;
  logic [CW-1:0]                 pidx;
  logic [scd_pkg::TIME_W-1:0]    deadline;

  logic                          new_bank;
  logic                          in_range;
  logic [CW-1:0]                 pidx_inc;
  logic                          restart;
  logic                          skip;
  logic                          ref_mode;
  logic                          cmp_mode;
  logic                          cmp_add;
  logic [scd_pkg::TIME_W:0]      deadline_sum;
  logic [scd_pkg::TIME_W-1:0]    deadline_adv;

  assign point_stall = !take || pending;
  assign accept      = point_valid && !point_stall;

  assign new_bank  = ~ref_bank;
  assign in_range  = pidx < MAX_CNT;
  assign pidx_inc  = in_range ? pidx + CW'(1) : pidx;
  assign restart   = point.req_type == scd_pkg::REQ_RESTART;
  assign skip      = !restart && (point.scan_time < deadline);
  assign ref_mode  = !restart && !skip && !have_ref;
  assign cmp_mode  = !restart && !skip && have_ref;
  assign cmp_add   = cmp_mode && (pidx < ref_count);

  assign deadline_sum = {1'b0, deadline} + (scd_pkg::TIME_W+1)'(time_increment);
  assign deadline_adv = deadline_sum[scd_pkg::TIME_W] ? scd_pkg::DEADLINE_MAX
                                                       : deadline_sum[scd_pkg::TIME_W-1:0];

  assign mem_we    = accept && ((ref_mode && in_range) || cmp_add);
  assign mem_waddr = {new_bank, pidx[AW-1:0]};
  assign mem_wdata = point.sample;
  assign mem_re    = accept && cmp_add;
  assign mem_raddr = {ref_bank, pidx[AW-1:0]};

  always_comb begin
    item.emit    = !restart && point.last_point;
    item.add     = cmp_add;
    item.clr     = restart || point.last_point;
    item.resolve = cmp_mode && point.last_point;
    item.sample  = point.sample;
    if (skip) begin
      item.kind  = scd_pkg::KIND_SKIP;
      item.count = have_ref ? scd_pkg::OUT_CNT_W'(ref_count) : '0;
    end else if (!have_ref) begin
      item.kind  = scd_pkg::KIND_REF;
      item.count = scd_pkg::OUT_CNT_W'(pidx_inc);
    end else begin
      item.kind  = scd_pkg::KIND_CMP;
      item.count = scd_pkg::OUT_CNT_W'(ref_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_ref  <= 1'b0;
      ref_bank  <= 1'b0;
      ref_count <= '0;
      pidx      <= '0;
      deadline  <= scd_pkg::TIME_W'(scd_pkg::TIME_INC_RESET);
      pending   <= 1'b0;
    end else begin
      if (accept) begin
        if (restart) begin
          have_ref <= 1'b0;
          pidx     <= '0;
          deadline <= scd_pkg::TIME_W'(time_increment);
        end else if (skip) begin
          if (point.last_point) begin
            pidx <= '0;
          end
        end else if (!have_ref) begin
          if (point.last_point) begin
            ref_count <= pidx_inc;
            have_ref  <= 1'b1;
            ref_bank  <= new_bank;
            pidx      <= '0;
          end else begin
            pidx <= pidx_inc;
          end
        end else begin
          if (point.last_point) begin
            deadline <= deadline_adv;
            pidx     <= '0;
            // bank choice for the next scan waits on the convergence decision
            pending  <= 1'b1;
          end else begin
            pidx <= pidx_inc;
          end
        end
      end
      if (resolve.valid) begin
        pending <= 1'b0;
        if (resolve.flip) begin
          ref_bank <= ~ref_bank;
        end
      end
    end
  end

endmodule

// ===== rtl/scd_accum.sv =====
// squared-difference pipeline, saturating accumulator and result register
module scd_accum #(
  parameter int CW = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  scd_pkg::scd_item_t                  item,
  input  logic signed [scd_pkg::SAMPLE_W-1:0] rdata,
  input  logic [scd_pkg::TOL_W-1:0]           tolerance,
  input  logic [CW-1:0]                       ref_count,
  output logic                                take,
  output scd_pkg::scd_resolve_t               resolve,
  output logic                                result_valid,
  input  logic                                result_stall,
  output scd_pkg::scd_result_t                result
);

  localparam int PW   = scd_pkg::TOL_W + CW;
  localparam int CMPW = (PW > scd_pkg::ACC_W) ? PW : scd_pkg::ACC_W;

  logic                                v1;
  scd_pkg::scd_item_t                  it1;
  logic                                v2;
  scd_pkg::scd_item_t                  it2;
  logic [scd_pkg::SQ_W-1:0]            sq2;
  logic [PW-1:0]                       prod2;
  logic [scd_pkg::ACC_W-1:0]           acc;

  logic signed [scd_pkg::SAMPLE_W:0]   diff;
  logic [scd_pkg::SAMPLE_W-1:0]        mag;
  logic [scd_pkg::SQ_W-1:0]            sq1;
  logic [PW-1:0]                       prod1;
  logic [scd_pkg::ACC_W:0]             acc_wide;
  logic [scd_pkg::ACC_W-1:0]           sum;
  logic                                conv;
  logic                                adv2;
  logic                                move2;
  logic [1:0]                          status;

  // stage 1: difference against the stored reference point, and its square
  assign diff  = {rdata[scd_pkg::SAMPLE_W-1], rdata}
               - {it1.sample[scd_pkg::SAMPLE_W-1], it1.sample};
  assign mag   = diff[scd_pkg::SAMPLE_W] ? scd_pkg::SAMPLE_W'(-diff)
                                         : diff[scd_pkg::SAMPLE_W-1:0];
  assign sq1   = scd_pkg::SQ_W'(mag) * scd_pkg::SQ_W'(mag);
  // ref_count is stable while the final point of a compared scan is in flight
  assign prod1 = PW'(tolerance) * PW'(ref_count);

  // stage 2: saturating accumulate and convergence test
  assign acc_wide = {1'b0, acc} + (scd_pkg::ACC_W+1)'(it2.add ? sq2 : '0);
  assign sum      = acc_wide[scd_pkg::ACC_W] ? scd_pkg::ACC_MAX
                                             : acc_wide[scd_pkg::ACC_W-1:0];
  assign conv     = CMPW'(sum) < CMPW'(prod2);

  assign adv2  = !v2 || !it2.emit || !result_valid || !result_stall;
  assign move2 = v2 && adv2;
  assign take  = !v1 || adv2;

  assign resolve.valid = move2 && it2.resolve;
  assign resolve.flip  = !conv;

  always_comb begin
    unique case (it2.kind)
      scd_pkg::KIND_SKIP: status = scd_pkg::ST_SKIPPED;
      scd_pkg::KIND_REF:  status = scd_pkg::ST_REF_STORED;
      scd_pkg::KIND_CMP:  status = conv ? scd_pkg::ST_CONVERGED : scd_pkg::ST_NOT_CONVERGED;
      default:            status = scd_pkg::ST_SKIPPED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (take) begin
        v1 <= accept;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it1 <= item;
    end
    if (adv2 && v1) begin
      it2   <= it1;
      sq2   <= sq1;
      prod2 <= prod1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (move2) begin
      acc <= it2.clr ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (move2 && it2.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move2 && it2.emit) begin
      result.status      <= status;
      result.sum_squares <= (it2.kind == scd_pkg::KIND_CMP) ? sum : '0;
      result.point_count <= it2.count;
    end
  end

endmodule
